[rtl/ivc_pkg.sv]
package ivc_pkg;

  localparam int MaxVertices = 64;
  localparam int VidW        = 6;
  localparam int CntW        = 7;
  localparam int RowW        = 64;
  localparam int HistW       = 64;
  localparam int HistDepth   = MaxVertices + 1;

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdAdd   = 2'd2;
  localparam logic [1:0] CmdRead  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadVert = 2'd1;
  localparam logic [1:0] StDup     = 2'd2;
  localparam logic [1:0] StBadBin  = 2'd3;

  // Token that travels down the cell chain
  typedef struct packed {
    logic                   valid;
    logic [MaxVertices-1:0] mask;
    logic [CntW-1:0]        cnt;
  } chain_link_t;

  // Broadcast relabel command to all cells
  typedef struct packed {
    logic                   en;
    logic [MaxVertices-1:0] merge;
    logic [VidW-1:0]        label;
  } relabel_t;

endpackage

[rtl/ivc_ram.sv]
module ivc_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ivc_cell.sv]
module ivc_cell
  import ivc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [VidW-1:0] cell_id_i,
  input  logic            nb_i,
  input  logic            present_i,
  input  chain_link_t     link_i,
  input  relabel_t        relabel_i,
  output chain_link_t     link_o
);

  logic [VidW-1:0]        label_q, label_d;
  chain_link_t            link_d;
  logic                   valid_q;
  logic [MaxVertices-1:0] mask_q;
  logic [CntW-1:0]        cnt_q;
  logic                   hit;

  // Collect this vertex's component into the token
  always_comb begin
    hit    = nb_i && !link_i.mask[label_q];
    link_d = link_i;
    if (nb_i) begin
      link_d.mask[label_q] = 1'b1;
    end
    if (hit) begin
      link_d.cnt = link_i.cnt + CntW'(1);
    end
  end

  // Relabel merged components and the new vertex
  always_comb begin
    label_d = label_q;
    if (relabel_i.en) begin
      if (cell_id_i == relabel_i.label) begin
        label_d = relabel_i.label;
      end else if (present_i && relabel_i.merge[label_q]) begin
        label_d = relabel_i.label;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= link_d.mask;
    cnt_q   <= link_d.cnt;
    label_q <= label_d;
  end

  assign link_o = '{valid: valid_q, mask: mask_q, cnt: cnt_q};

endmodule

[rtl/incremental_vertex_connectivity.sv]
// Load and rejected commands go straight to the response; start trial and histogram read
// use the histogram RAM; add vertex reads its row and runs the 64-cell label chain.
// Throughput: one transaction at a time; the next is accepted once the previous
// result is in the output register.
// Reset: adjacency rows, present set, counters and histogram clear at once through
// valid bits; vertex_count resets to 64. No clearing pass is needed.
module incremental_vertex_connectivity
  import ivc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [VidW-1:0]   vertex_i,
  input  logic [RowW-1:0]   neighbour_row_i,
  input  logic [CntW-1:0]   bin_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [CntW-1:0]   added_count_o,
  output logic              connected_o,
  output logic [HistW-1:0]  count_value_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SAdjRd = 3'd1;
  localparam logic [2:0] SAdj   = 3'd2;
  localparam logic [2:0] SChain = 3'd3;
  localparam logic [2:0] SHRd   = 3'd4;
  localparam logic [2:0] SHWr   = 3'd5;
  localparam logic [2:0] SResp  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        vcount_q, vcount_d;
  logic [MaxVertices-1:0] present_q, present_d;
  logic [MaxVertices-1:0] adj_vld_q, adj_vld_d;
  logic [HistDepth-1:0]   hist_vld_q, hist_vld_d;
  logic [CntW-1:0]        added_q, added_d;
  logic [CntW-1:0]        comps_q, comps_d;
  logic                   out_valid_q, out_valid_d;
  logic                   start_q, start_d;

  logic [1:0]             cmd_q, cmd_d;
  logic [VidW-1:0]        vert_q, vert_d;
  logic [CntW-1:0]        haddr_q, haddr_d;
  logic [MaxVertices-1:0] nb_q, nb_d;
  logic [1:0]             st_q, st_d;
  logic                   conn_q, conn_d;
  logic [HistW-1:0]       val_q, val_d;
  logic [1:0]             ost_q, ost_d;
  logic [CntW-1:0]        oadd_q, oadd_d;
  logic                   oconn_q, oconn_d;
  logic [HistW-1:0]       oval_q, oval_d;

  logic [CntW-1:0]        eff_n;
  logic                   accept;
  logic                   adj_we;
  logic [RowW-1:0]        adj_rdata;
  logic                   hist_we;
  logic [HistW-1:0]       hist_wdata;
  logic [HistW-1:0]       hist_rdata;
  logic [HistW-1:0]       hist_cur;
  logic                   vert_bad;
  logic [CntW-1:0]        comps_new;
  logic [CntW-1:0]        added_new;
  logic                   out_free;

  chain_link_t            links [MaxVertices+1];
  relabel_t               relabel;

  // Effective vertex count
  always_comb begin
    if (vcount_q == '0) begin
      eff_n = CntW'(1);
    end else if (vcount_q > CntW'(MaxVertices)) begin
      eff_n = CntW'(MaxVertices);
    end else begin
      eff_n = vcount_q;
    end
  end

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign vert_bad   = {1'b0, vertex_i} >= eff_n;
  assign adj_we     = accept && (command_i == CmdLoad) && !vert_bad;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hist_cur   = hist_vld_q[haddr_q] ? hist_rdata : '0;
  assign hist_wdata = (hist_cur == '1) ? hist_cur : hist_cur + HistW'(1);
  assign comps_new  = comps_q + CntW'(1) - links[MaxVertices].cnt;
  assign added_new  = (added_q < CntW'(MaxVertices)) ? added_q + CntW'(1) : added_q;

  ivc_ram #(.Width(RowW), .Depth(MaxVertices)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (vertex_i),
    .wdata_i (neighbour_row_i),
    .raddr_i (vert_q),
    .rdata_o (adj_rdata)
  );

  ivc_ram #(.Width(HistW), .Depth(HistDepth)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (haddr_q),
    .wdata_i (hist_wdata),
    .raddr_i (haddr_q),
    .rdata_o (hist_rdata)
  );

  // Head of the chain
  always_comb begin
    links[0].valid = start_q;
    links[0].mask  = '0;
    links[0].cnt   = '0;
  end

  for (genvar j = 0; j < MaxVertices; j++) begin : g_cell
    ivc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (VidW'(j)),
      .nb_i      (nb_q[j]),
      .present_i (present_q[j]),
      .link_i    (links[j]),
      .relabel_i (relabel),
      .link_o    (links[j+1])
    );
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    vcount_d    = cfg_we_i ? cfg_wdata_i : vcount_q;
    present_d   = present_q;
    adj_vld_d   = adj_vld_q;
    hist_vld_d  = hist_vld_q;
    added_d     = added_q;
    comps_d     = comps_q;
    start_d     = 1'b0;
    cmd_d       = cmd_q;
    vert_d      = vert_q;
    haddr_d     = haddr_q;
    nb_d        = nb_q;
    st_d        = st_q;
    conn_d      = conn_q;
    val_d       = val_q;
    ost_d       = ost_q;
    oadd_d      = oadd_q;
    oconn_d     = oconn_q;
    oval_d      = oval_q;
    hist_we     = 1'b0;
    relabel.en    = 1'b0;
    relabel.merge = links[MaxVertices].mask;
    relabel.label = vert_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_d   = command_i;
          vert_d  = vertex_i;
          haddr_d = bin_i;
          st_d    = StOk;
          conn_d  = 1'b0;
          val_d   = '0;
          unique case (command_i)
            CmdLoad: begin
              if (vert_bad) begin
                st_d = StBadVert;
              end else begin
                adj_vld_d[vertex_i] = 1'b1;
              end
              state_d = SResp;
            end
            CmdStart: begin
              present_d = '0;
              added_d   = '0;
              comps_d   = '0;
              haddr_d   = '0;
              state_d   = SHRd;
            end
            CmdAdd: begin
              if (vert_bad) begin
                st_d    = StBadVert;
                state_d = SResp;
              end else if (present_q[vertex_i]) begin
                st_d    = StDup;
                state_d = SResp;
              end else begin
                state_d = SAdjRd;
              end
            end
            default: begin
              if (bin_i > eff_n) begin
                st_d    = StBadBin;
                state_d = SResp;
              end else begin
                state_d = SHRd;
              end
            end
          endcase
        end
      end
      SAdjRd: begin
        state_d = SAdj;
      end
      SAdj: begin
        nb_d = (adj_vld_q[vert_q] ? adj_rdata : '0) & present_q;
        nb_d[vert_q] = 1'b0;
        start_d = 1'b1;
        state_d = SChain;
      end
      SChain: begin
        if (links[MaxVertices].valid) begin
          relabel.en        = 1'b1;
          present_d[vert_q] = 1'b1;
          comps_d           = comps_new;
          added_d           = added_new;
          if (comps_new == CntW'(1)) begin
            conn_d  = 1'b1;
            haddr_d = added_new;
            state_d = SHRd;
          end else begin
            state_d = SResp;
          end
        end
      end
      SHRd: begin
        state_d = SHWr;
      end
      SHWr: begin
        if (cmd_q == CmdRead) begin
          val_d = hist_cur;
        end else begin
          hist_we             = 1'b1;
          hist_vld_d[haddr_q] = 1'b1;
        end
        state_d = SResp;
      end
      SResp: begin
        if (out_free) begin
          ost_d       = st_q;
          oadd_d      = added_q;
          oconn_d     = conn_q;
          oval_d      = val_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      vcount_q    <= CntW'(MaxVertices);
      present_q   <= '0;
      adj_vld_q   <= '0;
      hist_vld_q  <= '0;
      added_q     <= '0;
      comps_q     <= '0;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      present_q   <= present_d;
      adj_vld_q   <= adj_vld_d;
      hist_vld_q  <= hist_vld_d;
      added_q     <= added_d;
      comps_q     <= comps_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    vert_q  <= vert_d;
    haddr_q <= haddr_d;
    nb_q    <= nb_d;
    st_q    <= st_d;
    conn_q  <= conn_d;
    val_q   <= val_d;
    ost_q   <= ost_d;
    oadd_q  <= oadd_d;
    oconn_q <= oconn_d;
    oval_q  <= oval_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = ost_q;
  assign added_count_o = oadd_q;
  assign connected_o   = oconn_q;
  assign count_value_o = oval_q;

endmodule

[tb/tb_incremental_vertex_connectivity.sv]
`timescale 1ns / 1ps

module tb_incremental_vertex_connectivity;
  import ivc_pkg::*;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [VidW-1:0] vtx;
    logic [RowW-1:0] row;
    logic [CntW-1:0] bin;
  } graph_op_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CntW-1:0]  added;
    logic             conn;
    logic [HistW-1:0] value;
  } graph_resp_t;

  localparam int unsigned CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] command_i;
  logic [VidW-1:0] vertex_i;
  logic [RowW-1:0] neighbour_row_i;
  logic [CntW-1:0] bin_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [1:0] status_o;
  logic [CntW-1:0] added_count_o;
  logic connected_o;
  logic [HistW-1:0] count_value_o;

  incremental_vertex_connectivity i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .vertex_i       (vertex_i),
    .neighbour_row_i(neighbour_row_i),
    .bin_i          (bin_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .added_count_o  (added_count_o),
    .connected_o    (connected_o),
    .count_value_o  (count_value_o)
  );

  // Mirror of the graph state
  logic [RowW-1:0]  adj_rows_q [MaxVertices];
  logic [MaxVertices-1:0] present_q;
  logic [VidW-1:0]  comp_label_q [MaxVertices];
  logic [CntW-1:0]  added_q;
  logic [HistW-1:0] conn_hist_q [HistDepth];
  logic [CntW-1:0]  vcount_q;

  graph_op_t   pending_ops[$];
  graph_resp_t expected_resps[$];
  int unsigned errors;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_connected;
  int unsigned cycles;
  bit          idle_en;

  function automatic int unsigned active_vertices();
    if (vcount_q == 0) return 1;
    if (vcount_q > MaxVertices) return MaxVertices;
    return vcount_q;
  endfunction

  function automatic void bump_hist(int unsigned k);
    if (conn_hist_q[k] != '1) conn_hist_q[k] = conn_hist_q[k] + 1;
  endfunction

  // Apply one transaction to the mirror and return its result
  function automatic graph_resp_t apply_graph_op(graph_op_t op);
    graph_resp_t r;
    int unsigned n;
    logic [VidW-1:0] old_lbl;
    logic [VidW-1:0] new_lbl;
    logic all_same;
    n = active_vertices();
    r = '0;
    case (op.cmd)
      CmdLoad: begin
        if (op.vtx >= n) r.status = StBadVert;
        else adj_rows_q[op.vtx] = op.row;
      end
      CmdStart: begin
        present_q = '0;
        added_q = '0;
        bump_hist(0);
      end
      CmdAdd: begin
        if (op.vtx >= n) begin
          r.status = StBadVert;
        end else if (present_q[op.vtx]) begin
          r.status = StDup;
        end else begin
          present_q[op.vtx] = 1'b1;
          comp_label_q[op.vtx] = op.vtx;
          new_lbl = op.vtx;
          // merge every present neighbour's component into the new vertex
          for (int j = 0; j < MaxVertices; j++) begin
            if (present_q[j] && adj_rows_q[op.vtx][j] && j != op.vtx &&
                comp_label_q[j] != new_lbl) begin
              old_lbl = comp_label_q[j];
              for (int k = 0; k < MaxVertices; k++)
                if (present_q[k] && comp_label_q[k] == old_lbl) comp_label_q[k] = new_lbl;
            end
          end
          if (added_q < MaxVertices) added_q = added_q + 1;
          all_same = 1'b1;
          for (int j = 0; j < MaxVertices; j++)
            if (present_q[j] && comp_label_q[j] != new_lbl) all_same = 1'b0;
          if (all_same) begin
            r.conn = 1'b1;
            bump_hist(added_q);
          end
        end
      end
      default: begin
        if (op.bin > n) r.status = StBadBin;
        else r.value = conn_hist_q[op.bin];
      end
    endcase
    r.added = added_q;
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (!idle_en || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(120, 15);
  endfunction

  function automatic logic [RowW-1:0] rand_row();
    logic [RowW-1:0] a;
    logic [RowW-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a & b & {$urandom, $urandom};
      1: return a | b;
      2: return a;
      default: return a & b;
    endcase
  endfunction

  function automatic void push_op(logic [1:0] cmd, int unsigned vtx,
                                  logic [RowW-1:0] row, int unsigned bin);
    graph_op_t op;
    op.cmd = cmd;
    op.vtx = vtx[VidW-1:0];
    op.row = row;
    op.bin = bin[CntW-1:0];
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  // One trial: reload some rows, then add a shuffled vertex order with some noise
  function automatic void push_trial(int unsigned n);
    int unsigned order[MaxVertices];
    int unsigned tmp;
    int unsigned idx;
    for (int i = 0; i < MaxVertices; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      idx = $urandom_range(i);
      tmp = order[i];
      order[i] = order[idx];
      order[idx] = tmp;
    end
    push_op(CmdStart, $urandom, {$urandom, $urandom}, $urandom);
    for (int i = 0; i < n; i++)
      if ($urandom_range(2) == 0) push_op(CmdLoad, i, rand_row(), $urandom);
    for (int i = 0; i < n; i++) begin
      push_op(CmdAdd, order[i], {$urandom, $urandom}, $urandom);
      case ($urandom_range(19))
        0: push_op(CmdAdd, order[$urandom_range(i)], rand_row(), $urandom);
        1: push_op(CmdAdd, $urandom_range(63), rand_row(), $urandom);
        2: push_op(CmdRead, $urandom, rand_row(), $urandom_range(n + 1));
        3: push_op(CmdRead, $urandom, rand_row(), $urandom_range(127));
        4: push_op(CmdLoad, $urandom_range(63), rand_row(), $urandom);
        default: ;
      endcase
    end
    if ($urandom_range(3) == 0) push_op(CmdRead, 0, '0, $urandom_range(n));
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drive input transactions from the pending queue
  int unsigned gap_q;
  graph_op_t cur_op;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i <= CmdLoad;
      vertex_i <= '0;
      neighbour_row_i <= '0;
      bin_i <= '0;
      gap_q <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur_op = '{command_i, vertex_i, neighbour_row_i, bin_i};
        expected_resps.insert(expected_resps.size(), apply_graph_op(cur_op));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_q > 0) begin
          gap_q <= gap_q - 1;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          command_i <= cur_op.cmd;
          vertex_i <= cur_op.vtx;
          neighbour_row_i <= cur_op.row;
          bin_i <= cur_op.bin;
          gap_q <= rand_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check results and stall the output at random
  int unsigned stall_q;
  graph_resp_t exp_r;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_q <= 0;
    end else begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_resps.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (exp_r.conn) n_connected++;
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, status_o);
            errors++;
          end
          if (added_count_o !== exp_r.added) begin
            $error("added_count: expected %0d actual %0d", exp_r.added, added_count_o);
            errors++;
          end
          if (connected_o !== exp_r.conn) begin
            $error("connected: expected %0d actual %0d", exp_r.conn, connected_o);
            errors++;
          end
          if (count_value_o !== exp_r.value) begin
            $error("count_value: expected %0h actual %0h", exp_r.value, count_value_o);
            errors++;
          end
        end
      end
      if (stall_q > 0) begin
        stall_q <= stall_q - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_q <= rand_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stop the run as failed past the cycle limit
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("incremental_vertex_connectivity regression: fail");
      $finish;
    end
  end

  // Sequence phases and configuration writes
  int unsigned cfg_vals[7] = '{1, 0, 127, 5, 64, 33, 2};
  int unsigned phase_items;
  initial begin
    errors = 0;
    n_accepted = 0;
    n_results = 0;
    n_connected = 0;
    cycles = 0;
    idle_en = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    present_q = '0;
    added_q = '0;
    vcount_q = 7'd64;
    for (int i = 0; i < MaxVertices; i++) begin
      adj_rows_q[i] = '0;
      comp_label_q[i] = '0;
    end
    for (int i = 0; i < HistDepth; i++) conn_hist_q[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command and each corner case
    push_op(CmdRead, 0, '0, 0);
    push_op(CmdStart, 63, '1, 127);
    push_op(CmdLoad, 0, '1, 0);
    push_op(CmdLoad, 63, '0, 0);
    push_op(CmdLoad, 1, 64'h1 << 1, 0);
    push_op(CmdAdd, 1, '0, 0);
    push_op(CmdAdd, 1, '0, 0);
    push_op(CmdAdd, 63, '0, 0);
    push_op(CmdAdd, 0, '0, 0);
    push_op(CmdRead, 0, '0, 1);
    push_op(CmdRead, 0, '0, 3);
    push_op(CmdRead, 0, '0, 64);
    push_op(CmdRead, 0, '0, 65);
    push_op(CmdRead, 0, '0, 127);
    push_op(CmdStart, 0, '0, 0);
    push_op(CmdAdd, 63, '0, 0);
    push_op(CmdLoad, 62, 64'h8000_0000_0000_0000, 0);
    push_op(CmdAdd, 62, '0, 0);
    push_op(CmdRead, 0, '0, 0);
    push_op(CmdRead, 0, '0, 2);

    // Random phases, each under the vertex count set by reset or by the last configuration write
    for (int ph = 0; ph <= 7; ph++) begin
      idle_en = (ph % 3 != 1);
      phase_items = 0;
      while (phase_items < 190) begin
        phase_items -= pending_ops.size();
        push_trial(active_vertices() > 12 && $urandom_range(3) != 0 ?
                   $urandom_range(12, 2) : active_vertices());
        phase_items += pending_ops.size();
      end
      wait (pending_ops.size() == 0 && !in_valid_i && expected_resps.size() == 0);
      repeat (10) @(posedge clk_i);
      if (ph < 7) begin
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= cfg_vals[ph][CntW-1:0];
        @(posedge clk_i);
        vcount_q = cfg_vals[ph][CntW-1:0];
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
    end

    repeat (80) @(posedge clk_i);
    $display("covered %0d transactions over 8 vertex counts incl. 0, 1 and 127",
             n_accepted);
    $display("%0d results checked, %0d adds reported a connected prefix",
             n_results, n_connected);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("incremental_vertex_connectivity regression: pass");
    end else begin
      if (expected_resps.size() != 0) $error("%0d results missing", expected_resps.size());
      $display("incremental_vertex_connectivity regression: fail");
    end
    $finish;
  end

endmodule
